FILE: hw/rtl/tti_pkg.sv
// Shared types and constants for the thermistor table interpolator.
// Used by the top level, the divider and the port checker.
`timescale 1ns / 1ps

package tti_pkg;

   // Channel and register port widths.
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 16;
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 8;

   // Field widths.
   localparam int MV_W     = 16;
   localparam int ENTRY_W  = 16;
   localparam int KELVIN_W = 9;

   // Interpolation datapath widths: |numerator| < 2^24, |denominator| < 2^16.
   localparam int MAG_W  = 24;
   localparam int DIV_W  = 16;
   localparam int PROD_W = MAG_W + 1;
   localparam int DEN_W  = DIV_W + 1;
   localparam int ACC_W  = MAG_W + 2;

   localparam int KELVIN_OFFSET = 273;
   localparam int KELVIN_MAX    = 511;

   localparam logic [7:0] SCALE_RESET = 8'd11;
   localparam logic [4:0] COUNT_RESET = 5'd13;

   localparam logic [CSR_ADDR_W-1:0] CSR_VOLTAGE_SCALE = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_PAIR_COUNT    = 1'd1;

   localparam logic OP_WRITE   = 1'b0;
   localparam logic OP_CONVERT = 1'b1;

   typedef enum logic [1:0] {
      STATUS_CONVERTED  = 2'd0,
      STATUS_READ_ERROR = 2'd1,
      STATUS_WRITE_DONE = 2'd2
   } status_type;

   typedef struct packed {
      logic             start;
      logic [MAG_W-1:0] dividend;
      logic [DIV_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [MAG_W-1:0] quotient;
   } div_rsp_type;

endpackage

FILE: hw/rtl/tti_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps

module tti_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

FILE: hw/rtl/tti_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on tti_pkg for widths and the request/response structs.
`timescale 1ns / 1ps

module tti_div
   import tti_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   localparam int CNT_W = $clog2(MAG_W);

   logic [MAG_W-1:0] quo_ff, quo_in;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] divisor_ff, divisor_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DIV_W:0]   trial;

   always_comb begin
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      cnt_in     = cnt_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      trial      = {rem_ff, quo_ff[MAG_W-1]};
      if (div_req.start) begin
         quo_in     = div_req.dividend;
         rem_in     = '0;
         divisor_in = div_req.divisor;
         cnt_in     = '0;
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor_ff}) begin
            rem_in = DIV_W'(trial - {1'b0, divisor_ff});
            quo_in = {quo_ff[MAG_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DIV_W-1:0];
            quo_in = {quo_ff[MAG_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(MAG_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

FILE: hw/rtl/thermistor_table_interpolator_top.sv
// Top level of the thermistor table interpolator: sequencer, table RAM and divider.
// Depends on tti_pkg, tti_ram and tti_div.
`timescale 1ns / 1ps

// A write or a read-error transaction goes from acceptance directly to S_OUT.
// A sample clamped at the first entry ends after the first-entry check, one clamped
// at the last entry after the last-entry check. An interpolated sample runs a binary
// search of at most 4 probes for 16 pairs; the serial divider takes most of its time.
// One transaction is in work at a time; the next is taken once the result is registered.
// Reset clears control state and sets scale 11 and pair count 13; table contents
// stay undefined until written, with no clearing pass.
module thermistor_table_interpolator_top
   import tti_pkg::*;
#(
   parameter int MAX_PAIRS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // entry_index, entry_voltage, entry_celsius, sample_mv, sample_ok, zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // opcode
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // temp_kelvin, zero pad
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // status
   output logic [1:0]            rsp_tuser,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int AW = $clog2(MAX_PAIRS);

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHK_FIRST,
      S_CHK_LAST,
      S_PROBE_MID,
      S_PROBE_NEXT,
      S_DECIDE,
      S_MUL,
      S_DIV_START,
      S_DIV_WAIT,
      S_OUT
   } state_type;

   state_type state_ff, state_in;

   logic [7:0]            scale_ff, scale_in;
   logic [4:0]            count_ff, count_in;
   logic [MV_W-1:0]       mv_ff, mv_in;
   logic [AW-1:0]         lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   logic [MV_W-1:0]       vh_ff, vh_in, vl_ff, vl_in;
   logic signed [7:0]     t_mid_ff, t_mid_in, t_next_ff, t_next_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [DEN_W-1:0]  den_ff, den_in;
   logic                  neg_ff, neg_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   status_type            status_ff, status_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [KELVIN_W-1:0]   rsp_kelvin_ff, rsp_kelvin_in;
   status_type            rsp_status_ff, rsp_status_in;

   logic [3:0]            req_index;
   logic [7:0]            req_voltage;
   logic [7:0]            req_celsius;
   logic [MV_W-1:0]       req_mv;
   logic                  req_ok;
   logic                  req_accept;

   logic                  ram_we;
   logic [AW-1:0]         ram_raddr;
   logic [ENTRY_W-1:0]    ram_rdata;
   logic [7:0]            rd_voltage;
   logic signed [7:0]     rd_celsius;
   logic [MV_W-1:0]       rd_scaled;

   logic [AW-1:0]         last_idx;
   logic [AW:0]           mid_sum;
   logic [AW-1:0]         mid_calc;
   logic [AW-1:0]         mid_plus;
   logic signed [MV_W+1:0]   diff_v;
   logic signed [8:0]        diff_t;
   logic signed [MV_W+10:0]  prod_full;
   logic signed [ACC_W-1:0]  quo_s;
   logic signed [ACC_W:0]    kel_wide;
   logic [KELVIN_W-1:0]   kel_sat;
   logic                  out_free;

   div_req_type           div_req;
   div_rsp_type           div_rsp;

   assign req_index   = req_tdata[3:0];
   assign req_voltage = req_tdata[11:4];
   assign req_celsius = req_tdata[19:12];
   assign req_mv      = req_tdata[35:20];
   assign req_ok      = req_tdata[36];

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign ram_we = req_accept && (req_tuser == OP_WRITE) && (int'(req_index) < MAX_PAIRS);

   tti_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(MAX_PAIRS)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (AW'(req_index)),
      .wdata ({req_voltage, req_celsius}),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   tti_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign rd_voltage = ram_rdata[15:8];
   assign rd_celsius = $signed(ram_rdata[7:0]);
   assign rd_scaled  = {8'd0, rd_voltage} * {8'd0, scale_ff};

   // Pair count below two acts as two, above the table size as the table size.
   always_comb begin
      if (int'(count_ff) > MAX_PAIRS) begin
         last_idx = AW'(MAX_PAIRS - 1);
      end else if (count_ff < 5'd2) begin
         last_idx = AW'(1);
      end else begin
         last_idx = AW'(count_ff - 5'd1);
      end
   end

   assign mid_sum  = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid_calc = mid_sum[AW:1];
   assign mid_plus = mid_ff + 1'b1;

   always_comb begin
      case (state_ff)
         S_CHK_FIRST:  ram_raddr = last_idx;
         S_PROBE_MID:  ram_raddr = mid_calc;
         S_PROBE_NEXT: ram_raddr = mid_plus;
         default:      ram_raddr = '0;
      endcase
   end

   assign diff_v    = $signed({2'b00, vh_ff}) - $signed({2'b00, mv_ff});
   assign diff_t    = $signed({t_next_ff[7], t_next_ff}) - $signed({t_mid_ff[7], t_mid_ff});
   assign prod_full = diff_v * diff_t;
   assign quo_s     = $signed({2'b00, div_rsp.quotient});

   assign kel_wide = (ACC_W+1)'(acc_ff) + (ACC_W+1)'(KELVIN_OFFSET);
   always_comb begin
      if (kel_wide < 0) begin
         kel_sat = '0;
      end else if (kel_wide > (ACC_W+1)'(KELVIN_MAX)) begin
         kel_sat = KELVIN_W'(KELVIN_MAX);
      end else begin
         kel_sat = kel_wide[KELVIN_W-1:0];
      end
   end

   always_comb begin
      state_in      = state_ff;
      scale_in      = scale_ff;
      count_in      = count_ff;
      mv_in         = mv_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      vh_in         = vh_ff;
      vl_in         = vl_ff;
      t_mid_in      = t_mid_ff;
      t_next_in     = t_next_ff;
      prod_in       = prod_ff;
      den_in        = den_ff;
      neg_in        = neg_ff;
      acc_in        = acc_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_kelvin_in = rsp_kelvin_ff;
      rsp_status_in = rsp_status_ff;
      div_req       = '0;

      if (csr_we) begin
         case (csr_addr)
            CSR_VOLTAGE_SCALE: scale_in = csr_wdata[7:0];
            CSR_PAIR_COUNT:    count_in = csr_wdata[4:0];
            default:           ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               mv_in = req_mv;
               if (req_tuser == OP_WRITE) begin
                  status_in = STATUS_WRITE_DONE;
                  state_in  = S_OUT;
               end else if (!req_ok) begin
                  status_in = STATUS_READ_ERROR;
                  state_in  = S_OUT;
               end else begin
                  status_in = STATUS_CONVERTED;
                  state_in  = S_CHK_FIRST;
               end
            end
         end
         S_CHK_FIRST: begin
            lo_in = '0;
            hi_in = last_idx;
            if (mv_ff > rd_scaled) begin
               acc_in   = ACC_W'(rd_celsius);
               state_in = S_OUT;
            end else begin
               state_in = S_CHK_LAST;
            end
         end
         S_CHK_LAST: begin
            if (mv_ff < rd_scaled) begin
               acc_in   = ACC_W'(rd_celsius);
               state_in = S_OUT;
            end else begin
               state_in = S_PROBE_MID;
            end
         end
         S_PROBE_MID: begin
            mid_in   = mid_calc;
            state_in = S_PROBE_NEXT;
         end
         S_PROBE_NEXT: begin
            vh_in    = rd_scaled;
            t_mid_in = rd_celsius;
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            vl_in     = rd_scaled;
            t_next_in = rd_celsius;
            // A search that closes without a hit keeps the last probed segment.
            if (mv_ff <= vh_ff && mv_ff >= rd_scaled) begin
               state_in = S_MUL;
            end else if (mv_ff > vh_ff) begin
               hi_in    = mid_ff;
               state_in = (lo_ff == mid_ff) ? S_MUL : S_PROBE_MID;
            end else begin
               lo_in    = mid_plus;
               state_in = (mid_plus == hi_ff) ? S_MUL : S_PROBE_MID;
            end
         end
         S_MUL: begin
            prod_in  = prod_full[PROD_W-1:0];
            den_in   = $signed({1'b0, vh_ff}) - $signed({1'b0, vl_ff});
            state_in = S_DIV_START;
         end
         S_DIV_START: begin
            if (den_ff == '0) begin
               acc_in   = ACC_W'(t_mid_ff);
               state_in = S_OUT;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = prod_ff[PROD_W-1] ? MAG_W'(-prod_ff) : MAG_W'(prod_ff);
               div_req.divisor  = den_ff[DEN_W-1] ? DIV_W'(-den_ff) : DIV_W'(den_ff);
               neg_in           = prod_ff[PROD_W-1] ^ den_ff[DEN_W-1];
               state_in         = S_DIV_WAIT;
            end
         end
         S_DIV_WAIT: begin
            if (div_rsp.done) begin
               acc_in   = ACC_W'(t_mid_ff) + (neg_ff ? -quo_s : quo_s);
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_kelvin_in = (status_ff == STATUS_CONVERTED) ? kel_sat : '0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         scale_ff     <= SCALE_RESET;
         count_ff     <= COUNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scale_ff     <= scale_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mv_ff         <= mv_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      mid_ff        <= mid_in;
      vh_ff         <= vh_in;
      vl_ff         <= vl_in;
      t_mid_ff      <= t_mid_in;
      t_next_ff     <= t_next_in;
      prod_ff       <= prod_in;
      den_ff        <= den_in;
      neg_ff        <= neg_in;
      acc_ff        <= acc_in;
      status_ff     <= status_in;
      rsp_kelvin_ff <= rsp_kelvin_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W-KELVIN_W)'(0), rsp_kelvin_ff};
   assign rsp_tuser  = rsp_status_ff;

endmodule

FILE: hw/rtl/tti_checker.sv
// Port-level checks for the thermistor table interpolator, bound to the top level.
// Depends on tti_pkg for widths and status codes.
`timescale 1ns / 1ps

module tti_checker
   import tti_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [1:0]            rsp_tuser
);

   // No result is offered right after reset.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result offered after reset");

   // A stalled result transaction holds its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // Write and read-error results carry a zero temperature.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != STATUS_CONVERTED |-> rsp_tdata == '0)
      else $error("non-conversion result with nonzero temperature");

   // One transaction at a time: the input closes right after an acceptance.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input still open after acceptance");

endmodule

bind thermistor_table_interpolator_top tti_checker u_tti_checker (.*);
